[hdl/tlsr_pkg.sv]
// Shared widths, codes and handshake structs of the tank level soak reporter.
package tlsr_pkg;

   localparam int LEVEL_W   = 4;
   localparam int CLASS_W   = 2;
   localparam int PCT_W     = 10;
   localparam int THR_W     = 16;
   localparam int COUNT_W   = 17;
   localparam int PROD_W    = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   localparam logic [COUNT_W-1:0] SOAK_MAX  = 17'h1FFFF;
   localparam logic [PROD_W-1:0]  PCT_SCALE = 11'd100;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL_RESET = 4'd9;
   localparam logic [THR_W-1:0]   SOAK_THR_RESET   = 16'd5;

   localparam logic [CLASS_W-1:0] CLS_MID   = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_FULL  = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_EMPTY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FULL_LEVEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOAK_THR   = 1'd1;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[hdl/tlsr_if.sv]
// Valid/ready channel interfaces for probe ticks and level reports.
interface tlsr_req_if #(parameter int PROBE_COUNT = 9);
   logic                   valid;
   logic                   ready;
   logic [PROBE_COUNT-1:0] probe_pins;
   logic                   other_report_pending;

   modport source (output valid, output probe_pins, output other_report_pending,
                   input ready);
   modport sink   (input valid, input probe_pins, input other_report_pending,
                   output ready);
endinterface

interface tlsr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tlsr_pkg::LEVEL_W-1:0]  level;
   logic [tlsr_pkg::CLASS_W-1:0]  level_class;
   logic [tlsr_pkg::PCT_W-1:0]    fill_percent;

   modport source (output valid, output level, output level_class, output fill_percent,
                   input ready);
   modport sink   (input valid, input level, input level_class, input fill_percent,
                   output ready);
endinterface

[hdl/tlsr_serial_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module tlsr_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  tlsr_pkg::div_ctrl_type        ctrl,
   input  logic [tlsr_pkg::PROD_W-1:0]   dividend,
   input  logic [tlsr_pkg::LEVEL_W-1:0]  divisor,
   output tlsr_pkg::div_stat_type        stat,
   output logic [tlsr_pkg::PROD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(tlsr_pkg::PROD_W);

   logic [tlsr_pkg::PROD_W-1:0]  q_ff, q_in;
   logic [tlsr_pkg::LEVEL_W-1:0] rem_ff, rem_in;
   logic [tlsr_pkg::LEVEL_W-1:0] div_ff;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [tlsr_pkg::LEVEL_W:0]   trial;
   logic                         fits;

   // The quotient bits shift in from the right as the dividend bits leave on the left.
   assign trial = {rem_ff, q_ff[tlsr_pkg::PROD_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[tlsr_pkg::PROD_W-2:0], fits};
         if (fits) begin
            rem_in = tlsr_pkg::LEVEL_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[tlsr_pkg::LEVEL_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(tlsr_pkg::PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (ctrl.start) begin
         div_ff <= divisor;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

[hdl/tank_level_soak_reporter_core.sv]
// Top level of the tank level soak reporter: probe scan, soak logic and report output.
//
// Usage: each item on req_chan is a one-second tick with active-low probe bits
// and a flag that another report is busy. The block scans the probe bits one
// per cycle to find the highest wetted probe, then updates the soak state.
// When the level has stayed steady past soak_threshold and no other report is
// pending, one report goes out on rsp_chan with the level, its class and
// 100*level/full_level.
// Timing: a tick that gives no report passes through the serial scan and the
// evaluation before req_chan.ready returns. A reporting tick also runs the
// eleven-step restoring divider before the report is in the output register.
// One item is in work at a time; the output register lets the next tick be
// accepted while a report still waits. If the receiver stalls and a second
// report finishes, the block holds it and keeps req_chan.ready low until the
// output register frees.
// Reset: synchronous, active high; it clears the soak state, the output valid
// and returns full_level to 9 and soak_threshold to 5. csr_we writes register
// csr_index (0 full_level, 1 soak_threshold) from csr_wdata.
module tank_level_soak_reporter_core #(
   parameter int PROBE_COUNT = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   tlsr_req_if.sink                         req_chan,
   tlsr_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [tlsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tlsr_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int LW = tlsr_pkg::LEVEL_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_LOAD = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [PROBE_COUNT-1:0]            pins_ff, pins_in;
   logic                              pend_ff, pend_in;
   logic [LW-1:0]                     scan_cnt_ff, scan_cnt_in;
   logic [LW-1:0]                     lvl_ff, lvl_in;
   logic [tlsr_pkg::CLASS_W-1:0]      cls_ff, cls_in;

   logic [LW-1:0]                     last_level_ff, last_level_in;
   logic [tlsr_pkg::COUNT_W-1:0]      soak_count_ff, soak_count_in;
   logic                              report_done_ff, report_done_in;

   logic [LW-1:0]                     full_level_ff;
   logic [tlsr_pkg::THR_W-1:0]        soak_thr_ff;

   logic                              out_valid_ff, out_valid_in;
   logic [LW-1:0]                     out_level_ff;
   logic [tlsr_pkg::CLASS_W-1:0]      out_class_ff;
   logic [tlsr_pkg::PCT_W-1:0]        out_pct_ff;
   logic                              out_load;

   tlsr_pkg::div_ctrl_type            div_ctrl;
   tlsr_pkg::div_stat_type            div_stat;
   logic [tlsr_pkg::PROD_W-1:0]       div_quot;
   logic [tlsr_pkg::PROD_W-1:0]       product;

   logic                              changed;
   logic [tlsr_pkg::COUNT_W-1:0]      count_base;
   logic [tlsr_pkg::COUNT_W-1:0]      count_next;
   logic                              fire;

   assign product = tlsr_pkg::PROD_W'(lvl_ff) * tlsr_pkg::PCT_SCALE;

   // Soak decision for the level that the scan just found.
   always_comb begin
      changed    = lvl_ff != last_level_ff;
      count_base = changed ? '0 : soak_count_ff;
      count_next = (count_base < tlsr_pkg::SOAK_MAX) ? count_base + 1'b1 : count_base;
      fire       = (changed || !report_done_ff) && !pend_ff &&
                   (count_next > {1'b0, soak_thr_ff});
   end

   assign out_load = (state_ff == ST_LOAD) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in       = state_ff;
      pins_in        = pins_ff;
      pend_in        = pend_ff;
      scan_cnt_in    = scan_cnt_ff;
      lvl_in         = lvl_ff;
      cls_in         = cls_ff;
      last_level_in  = last_level_ff;
      soak_count_in  = soak_count_ff;
      report_done_in = report_done_ff;
      div_ctrl.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               pins_in     = req_chan.probe_pins[PROBE_COUNT-1:0];
               pend_in     = req_chan.other_report_pending;
               scan_cnt_in = '0;
               lvl_in      = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // A low bit means that probe is wet; later bits are higher probes.
            if (!pins_ff[0]) begin
               lvl_in = scan_cnt_ff + 1'b1;
            end
            pins_in     = pins_ff >> 1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == LW'(PROBE_COUNT - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            last_level_in = lvl_ff;
            if (changed || !report_done_ff) begin
               soak_count_in  = count_next;
               report_done_in = changed ? 1'b0 : report_done_ff;
            end
            if (lvl_ff >= full_level_ff) begin
               cls_in = tlsr_pkg::CLS_FULL;
            end else if (lvl_ff == '0) begin
               cls_in = tlsr_pkg::CLS_EMPTY;
            end else begin
               cls_in = tlsr_pkg::CLS_MID;
            end
            if (fire) begin
               report_done_in = 1'b1;
               div_ctrl.start = 1'b1;
               state_in       = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_level_ff  <= '0;
         soak_count_ff  <= '0;
         report_done_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         full_level_ff  <= tlsr_pkg::FULL_LEVEL_RESET;
         soak_thr_ff    <= tlsr_pkg::SOAK_THR_RESET;
      end else begin
         state_ff       <= state_in;
         last_level_ff  <= last_level_in;
         soak_count_ff  <= soak_count_in;
         report_done_ff <= report_done_in;
         out_valid_ff   <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               tlsr_pkg::CSR_FULL_LEVEL: full_level_ff <= csr_wdata[LW-1:0];
               tlsr_pkg::CSR_SOAK_THR:   soak_thr_ff   <= csr_wdata[tlsr_pkg::THR_W-1:0];
               default: ;
            endcase
         end
      end
      pins_ff     <= pins_in;
      pend_ff     <= pend_in;
      scan_cnt_ff <= scan_cnt_in;
      lvl_ff      <= lvl_in;
      cls_ff      <= cls_in;
      if (out_load) begin
         out_level_ff <= lvl_ff;
         out_class_ff <= cls_ff;
         // A zero full_level reports zero rather than the divider's all-ones quotient.
         out_pct_ff   <= (full_level_ff == '0) ? '0 : div_quot[tlsr_pkg::PCT_W-1:0];
      end
   end

   tlsr_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (product),
      .divisor  (full_level_ff),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign req_chan.ready        = state_ff == ST_IDLE;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.level        = out_level_ff;
   assign rsp_chan.level_class  = out_class_ff;
   assign rsp_chan.fill_percent = out_pct_ff;

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("ready raised while an item is in work");

   a_done_has_count: assert property (@(posedge clock) disable iff (reset)
      report_done_ff |-> (soak_count_ff != '0))
      else $error("report marked done with an empty soak count");

   a_full_class: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_class_ff == tlsr_pkg::CLS_FULL) ==
                        (out_level_ff >= full_level_ff)))
      else $error("full class disagrees with full_level");

   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV))
      else $error("divider running outside the divide state");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the tank level soak reporter with its own level and soak predictor.
module tb_top;

   localparam int PROBE_COUNT   = 9;
   localparam int REPORT_CYCLES = PROBE_COUNT + 14;
   localparam int SETTLE_CYCLES = 2 * REPORT_CYCLES;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_TICKS  = 1600;
   localparam int LONG_SOAK_THR = 100;
   localparam int SOAK_TICKS    = LONG_SOAK_THR + 3;
   localparam int LIMIT_CYCLES  = 1_000_000;

   typedef struct packed {
      logic [PROBE_COUNT-1:0] pins;
      logic                   pending;
   } probe_tick_type;

   typedef struct packed {
      logic [tlsr_pkg::LEVEL_W-1:0] level;
      logic [tlsr_pkg::CLASS_W-1:0] level_class;
      logic [tlsr_pkg::PCT_W-1:0]   fill_percent;
   } level_report_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           csr_we    = 1'b0;
   logic [tlsr_pkg::CSR_IDX_W-1:0] csr_index = tlsr_pkg::CSR_FULL_LEVEL;
   logic [tlsr_pkg::CSR_W-1:0]     csr_wdata = '0;

   tlsr_req_if #(.PROBE_COUNT(PROBE_COUNT)) req_chan ();
   tlsr_rsp_if                              rsp_chan ();

   tank_level_soak_reporter_core #(.PROBE_COUNT(PROBE_COUNT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the configuration and the soak state.
   logic [tlsr_pkg::LEVEL_W-1:0] model_full_level;
   logic [tlsr_pkg::THR_W-1:0]   model_soak_thr;
   logic [tlsr_pkg::LEVEL_W-1:0] held_level;
   logic [tlsr_pkg::COUNT_W-1:0] soak_ticks;
   logic                         level_reported;

   probe_tick_type   tick_backlog[$];
   level_report_type awaited_reports[$];

   int  gap_left;
   int  stall_left;
   int  hold_requests;
   int  holds_served;
   int  ticks_accepted;
   int  reports_checked;
   int  csr_writes;
   int  error_count;
   int  cycle_count;
   bit  sender_idles   = 1'b1;
   bit  receiver_idles = 1'b1;

   function automatic logic [tlsr_pkg::LEVEL_W-1:0] wet_level(
      input logic [PROBE_COUNT-1:0] pins);
      logic [tlsr_pkg::LEVEL_W-1:0] lvl;
      lvl = '0;
      for (int i = 0; i < PROBE_COUNT; i++)
         if (!pins[i]) lvl = tlsr_pkg::LEVEL_W'(i + 1);
      return lvl;
   endfunction

   function automatic bit predict_tick(input probe_tick_type tick,
                                       output level_report_type rpt);
      logic [tlsr_pkg::LEVEL_W-1:0] lvl;
      logic [tlsr_pkg::PROD_W-1:0]  scaled;
      lvl = wet_level(tick.pins);
      rpt = '0;
      if (lvl != held_level) begin
         held_level     = lvl;
         soak_ticks     = '0;
         level_reported = 1'b0;
      end
      if (level_reported)
         return 1'b0;
      if (soak_ticks != tlsr_pkg::SOAK_MAX)
         soak_ticks = soak_ticks + 1'b1;
      if (tick.pending || soak_ticks <= tlsr_pkg::COUNT_W'(model_soak_thr))
         return 1'b0;
      rpt.level = lvl;
      if (lvl >= model_full_level)
         rpt.level_class = tlsr_pkg::CLS_FULL;
      else if (lvl == '0)
         rpt.level_class = tlsr_pkg::CLS_EMPTY;
      else
         rpt.level_class = tlsr_pkg::CLS_MID;
      scaled = tlsr_pkg::PCT_SCALE * tlsr_pkg::PROD_W'(lvl);
      if (model_full_level == '0)
         rpt.fill_percent = '0;
      else
         rpt.fill_percent = tlsr_pkg::PCT_W'(scaled / tlsr_pkg::PROD_W'(model_full_level));
      level_reported = 1'b1;
      return 1'b1;
   endfunction

   // Wets the probe for the given level, keeps every higher probe dry and
   // leaves the lower probes random, since they cannot change the level.
   function automatic logic [PROBE_COUNT-1:0] pins_for_level(input int lvl);
      logic [PROBE_COUNT-1:0] pins;
      pins = '1;
      if (lvl > 0) begin
         for (int i = 0; i < lvl - 1; i++)
            pins[i] = 1'($urandom_range(0, 1));
         pins[lvl-1] = 1'b0;
      end
      return pins;
   endfunction

   task automatic queue_tick(input logic [PROBE_COUNT-1:0] pins, input logic pend);
      probe_tick_type tick;
      tick.pins    = pins;
      tick.pending = pend;
      tick_backlog.push_back(tick);
   endtask

   task automatic write_csr(input logic [tlsr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tlsr_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == tlsr_pkg::CSR_FULL_LEVEL)
         model_full_level = data[tlsr_pkg::LEVEL_W-1:0];
      else
         model_soak_thr = data[tlsr_pkg::THR_W-1:0];
      csr_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every tick is taken and every report has come, then lets a
   // tick that gives no report finish its scan.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (tick_backlog.size() != 0 || req_chan.valid || awaited_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Sender: offers the backlog one item at a time with a random gap per item while sender_idles is set.
   always @(posedge clock) begin
      probe_tick_type   tick;
      level_report_type rpt;
      logic             offering;
      if (reset) begin
         req_chan.valid                <= 1'b0;
         req_chan.probe_pins           <= '1;
         req_chan.other_report_pending <= 1'b0;
         gap_left = 0;
      end else begin
         offering = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            tick.pins    = req_chan.probe_pins;
            tick.pending = req_chan.other_report_pending;
            if (predict_tick(tick, rpt))
               awaited_reports.push_back(rpt);
            ticks_accepted++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (tick_backlog.size() != 0) begin
               tick = tick_backlog.pop_front();
               req_chan.probe_pins           <= tick.pins;
               req_chan.other_report_pending <= tick.pending;
               offering = 1'b1;
               gap_left = sender_idles ? $urandom_range(0, 5) : 0;
            end
         end
         req_chan.valid <= offering;
      end
   end

   // Receiver: checks each report against the oldest expectation.
   always @(posedge clock) begin
      level_report_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            reports_checked++;
            if (awaited_reports.size() == 0) begin
               error_count++;
               $display("%0t: unexpected report, expected none, actual level %0d class %0d pct %0d",
                        $time, rsp_chan.level, rsp_chan.level_class, rsp_chan.fill_percent);
            end else begin
               want = awaited_reports.pop_front();
               check_field("level", want.level, rsp_chan.level);
               check_field("level_class", want.level_class, rsp_chan.level_class);
               check_field("fill_percent", want.fill_percent, rsp_chan.fill_percent);
            end
            stall_left = receiver_idles ? $urandom_range(0, 5) : 0;
         end
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run stopped after %0d cycles with work outstanding", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int                           lvl;
      int                           run_len;
      int                           chunk_len;
      int                           queued;
      int                           thr_cap;
      logic [tlsr_pkg::LEVEL_W-1:0] ml;
      logic [tlsr_pkg::THR_W-1:0]   thr;
      logic                         pend;

      model_full_level = tlsr_pkg::FULL_LEVEL_RESET;
      model_soak_thr   = tlsr_pkg::SOAK_THR_RESET;
      held_level       = '0;
      soak_ticks       = '0;
      level_reported   = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty, full, steady after a report, deferred report, mid levels.
      write_csr(tlsr_pkg::CSR_FULL_LEVEL, tlsr_pkg::CSR_W'(9));
      write_csr(tlsr_pkg::CSR_SOAK_THR, tlsr_pkg::CSR_W'(1));
      repeat (3) queue_tick('1, 1'b0);
      repeat (2) queue_tick('0, 1'b0);
      queue_tick(9'h0FF, 1'b0);
      queue_tick(9'h1FE, 1'b0);
      queue_tick(9'h1FE, 1'b1);
      queue_tick(9'h1FE, 1'b0);
      repeat (2) queue_tick(9'h17F, 1'b0);
      wait_drained();

      // A zero divisor makes every level full with a zero percentage.
      write_csr(tlsr_pkg::CSR_FULL_LEVEL, tlsr_pkg::CSR_W'(0));
      repeat (2) queue_tick(9'h1EF, 1'b0);
      repeat (2) queue_tick('1, 1'b0);
      wait_drained();

      // Level 9 over a divisor of 1 gives the widest percentage.
      write_csr(tlsr_pkg::CSR_FULL_LEVEL, tlsr_pkg::CSR_W'(1));
      repeat (2) queue_tick(9'h0FF, 1'b0);
      wait_drained();

      write_csr(tlsr_pkg::CSR_FULL_LEVEL, 16'hFFF0 | tlsr_pkg::CSR_W'(15));
      repeat (2) queue_tick(9'h1BF, 1'b0);
      wait_drained();
      write_csr(tlsr_pkg::CSR_SOAK_THR, tlsr_pkg::CSR_W'(0));
      queue_tick('1, 1'b0);
      wait_drained();

      // Every tick reports while the receiver holds off, so the block backs up.
      write_csr(tlsr_pkg::CSR_FULL_LEVEL, tlsr_pkg::CSR_W'(9));
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      hold_requests++;
      for (int i = 0; i < 24; i++)
         queue_tick(pins_for_level((i % 2 == 0) ? 3 : 6), 1'b0);
      wait_drained();

      // Long soak: past the threshold only pending ticks, so the report
      // comes on the first tick that is not pending.
      write_csr(tlsr_pkg::CSR_SOAK_THR, tlsr_pkg::CSR_W'(LONG_SOAK_THR));
      lvl = $urandom_range(1, PROBE_COUNT);
      if (lvl == held_level)
         lvl = lvl % PROBE_COUNT + 1;
      for (int k = 1; k <= SOAK_TICKS; k++) begin
         pend = (k > LONG_SOAK_THR) ? 1'b1 : 1'($urandom_range(0, 1));
         queue_tick(pins_for_level(lvl), pend);
      end
      repeat (3) queue_tick(pins_for_level(lvl), 1'b0);
      wait_drained();

      // Random phase: mostly steady runs of one level, some noise.
      queued = 0;
      while (queued < RANDOM_TICKS) begin
         case ($urandom_range(0, 7))
            0:       ml = '0;
            1:       ml = tlsr_pkg::LEVEL_W'(1);
            2:       ml = tlsr_pkg::LEVEL_W'(15);
            3:       ml = tlsr_pkg::FULL_LEVEL_RESET;
            default: ml = tlsr_pkg::LEVEL_W'($urandom_range(1, 9));
         endcase
         case ($urandom_range(0, 9))
            0:       thr = '0;
            1:       thr = tlsr_pkg::THR_W'($urandom_range(7, 40));
            2:       thr = tlsr_pkg::THR_W'($urandom);
            default: thr = tlsr_pkg::THR_W'($urandom_range(0, 6));
         endcase
         write_csr(tlsr_pkg::CSR_FULL_LEVEL,
                   (tlsr_pkg::CSR_W'($urandom) & ~tlsr_pkg::CSR_W'(15)) | tlsr_pkg::CSR_W'(ml));
         write_csr(tlsr_pkg::CSR_SOAK_THR, tlsr_pkg::CSR_W'(thr));
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         thr_cap   = (int'(thr) > 12) ? 12 : int'(thr);
         chunk_len = $urandom_range(100, 200);
         for (int n = 0; n < chunk_len; ) begin
            if ($urandom_range(0, 99) < 85) begin
               lvl     = $urandom_range(0, PROBE_COUNT);
               run_len = $urandom_range(1, thr_cap + 4);
               for (int r = 0; r < run_len; r++)
                  queue_tick(pins_for_level(lvl), 1'($urandom_range(0, 3) == 0));
               n += run_len;
            end else begin
               queue_tick(PROBE_COUNT'($urandom), 1'($urandom_range(0, 1)));
               n++;
            end
         end
         queued += tick_backlog.size();
         wait_drained();
      end

      if (awaited_reports.size() != 0) begin
         error_count++;
         $display("%0t: %0d reports never arrived", $time, awaited_reports.size());
      end
      $display("Sent %0d probe ticks under %0d register writes, including a long soak.",
               ticks_accepted, csr_writes);
      $display("Checked %0d level reports across receiver hold-offs and sender pauses.",
               reports_checked);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
